>>> rtl/ake_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ake_pkg
// Shared types, constants and tables for the AES-128 key expansion block.
// ----------------------------------------------------------------------------
package ake_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned WordCnt  = 4;
    localparam int unsigned RoundW   = 4;
    localparam int unsigned KeyW     = WordW * WordCnt;
    localparam int unsigned HalfW    = KeyW / 2;
    // 4-bit round index + 128-bit round key, padded to whole bytes
    localparam int unsigned OutDataW = ((RoundW + KeyW + 7) / 8) * 8;

    localparam logic [RoundW-1:0] RoundFirst = 4'd0;
    localparam logic [RoundW-1:0] RoundLast  = 4'd10;

    typedef logic [WordW-1:0] t_word;
    typedef logic [RoundW-1:0] t_round;

    // Per-cycle control handed to every word cell
    typedef struct packed {
        logic load;   // take the cipher key word
        logic step;   // advance to the next round key word
    } t_cell_ctrl;

    // AES forward S-box
    localparam logic [7:0] SBOX [0:255] = '{
        8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
        8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
        8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
        8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
        8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
        8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
        8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
        8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
        8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
        8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
        8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
        8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
        8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
        8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
        8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
        8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
        8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
        8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
        8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
        8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
        8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
        8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
        8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
        8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
        8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
        8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
        8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
        8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
        8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
        8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    // Round constant used when stepping from round r to round r+1
    function automatic logic [7:0] rcon_next(input t_round r);
        logic [7:0] c;
        case (r)
            4'd0:    c = 8'h01;
            4'd1:    c = 8'h02;
            4'd2:    c = 8'h04;
            4'd3:    c = 8'h08;
            4'd4:    c = 8'h10;
            4'd5:    c = 8'h20;
            4'd6:    c = 8'h40;
            4'd7:    c = 8'h80;
            4'd8:    c = 8'h1b;
            4'd9:    c = 8'h36;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/ake_sub_word.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ake_sub_word
// RotWord, SubWord and round constant on the last word of the round key;
// feeds the head of the word cell chain.
// ----------------------------------------------------------------------------
module ake_sub_word (
    input  ake_pkg::t_word  i_word,
    input  ake_pkg::t_round i_round,
    output ake_pkg::t_word  o_temp
);
    import ake_pkg::*;

    t_word rot;
    t_word sub;

    // rotate left one byte
    assign rot = {i_word[23:0], i_word[31:24]};

    // byte-wise S-box
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            sub[b*8 +: 8] = sbox(rot[b*8 +: 8]);
        end
    end

    // round constant into the first (most significant) byte
    assign o_temp = {sub[31:24] ^ rcon_next(i_round), sub[23:0]};

endmodule

>>> rtl/ake_word_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ake_word_cell
// One 32-bit word of the round key. On a step the word becomes itself XOR
// the new word of its left neighbor, which it then hands on to the right.
// ----------------------------------------------------------------------------
module ake_word_cell (
    input  logic                i_clk,
    input  ake_pkg::t_cell_ctrl i_ctrl,
    input  ake_pkg::t_word      i_key_word,
    input  ake_pkg::t_word      i_chain,
    output ake_pkg::t_word      o_chain,
    output ake_pkg::t_word      o_word
);
    import ake_pkg::*;

    t_word r_word;
    t_word n_word;

    // new word of the next round, passed to the neighbor
    assign o_chain = r_word ^ i_chain;

    always_comb begin
        n_word = r_word;
        if (i_ctrl.load) begin
            n_word = i_key_word;
        end else if (i_ctrl.step) begin
            n_word = o_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

>>> rtl/aes128_key_expansion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_key_expansion_top
// Round key 0 is on the output in the cycle after the key is accepted.
// Each key gives round keys 0 to 10, one round key per cycle while m_axis_tready
// is high, from the word cell chain that makes each round key from the previous one.
// A new key is taken in the cycle round key 10 is taken.
// Reset (synchronous, active low) empties the output; no key is in work.
// ----------------------------------------------------------------------------
module aes128_key_expansion_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [63:0] cipher_key_high, [127:64] cipher_key_low
    input  logic [ake_pkg::KeyW-1:0]        s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] round_number, [67:4] round_key_high, [131:68] round_key_low,
    // [135:132] zero
    output logic [ake_pkg::OutDataW-1:0]    m_axis_tdata,
    output logic                            m_axis_tlast
);
    import ake_pkg::*;

    logic       r_busy;
    logic       n_busy;
    t_round     r_round;
    t_round     n_round;
    logic       s_fire;
    logic       m_fire;
    logic       last;
    t_cell_ctrl ctrl;
    t_word      temp;
    t_word      key_word [WordCnt];
    t_word      chain    [WordCnt+1];
    t_word      word     [WordCnt];

    assign last   = (r_round == RoundLast);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    // key accepted when idle or when the final round key leaves this cycle
    assign s_axis_tready = !r_busy || (m_axis_tready && last);

    assign ctrl.load = s_fire;
    assign ctrl.step = m_fire && !last;

    // key words, word 0 from the top word of the high half
    assign key_word[0] = s_axis_tdata[HalfW-1 -: WordW];
    assign key_word[1] = s_axis_tdata[WordW-1:0];
    assign key_word[2] = s_axis_tdata[KeyW-1 -: WordW];
    assign key_word[3] = s_axis_tdata[HalfW +: WordW];

    ake_sub_word u_sub_word (
        .i_word  (word[WordCnt-1]),
        .i_round (r_round),
        .o_temp  (temp)
    );

    assign chain[0] = temp;

    // chain of word cells
    for (genvar g = 0; g < WordCnt; g++) begin : g_cell
        ake_word_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_key_word (key_word[g]),
            .i_chain    (chain[g]),
            .o_chain    (chain[g+1]),
            .o_word     (word[g])
        );
    end

    // round counter and output valid
    always_comb begin
        n_busy  = r_busy;
        n_round = r_round;
        if (s_fire) begin
            n_busy  = 1'b1;
            n_round = RoundFirst;
        end else if (m_fire) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_round = r_round + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= RoundFirst;
        end else begin
            r_busy  <= n_busy;
            r_round <= n_round;
        end
    end

    // output item
    assign m_axis_tvalid = r_busy;
    assign m_axis_tlast  = last;
    assign m_axis_tdata  = {{(OutDataW-RoundW-KeyW){1'b0}},
                            word[2], word[3], word[0], word[1], r_round};

    // assertions
    a_load_round0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (m_axis_tvalid && r_round == RoundFirst))
        else $error("key accepted but round key 0 not presented");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_fire && !last && !s_fire) |=>
            (m_axis_tvalid && r_round == $past(r_round) + 4'd1))
        else $error("round counter did not advance after a round key");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_round <= RoundLast))
        else $error("round counter beyond last round");

    a_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && r_busy) |-> (m_fire && last))
        else $error("new key accepted before the run finished");

endmodule
